// File: hw/rtl/rsmp_pkg.sv
// Package: shared types and register codes of the reservoir sampler.
`timescale 1ns / 1ps
`default_nettype none
package rsmp_pkg;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] REG_RES_SIZE  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_ASG_WIDTH = 2'd1;

  localparam logic [6:0] RES_SIZE_RST  = 7'd64;
  localparam logic [4:0] ASG_WIDTH_RST = 5'd1;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] elem_value;
    logic [15:0] accept_draw;
    logic [5:0]  slot_draw;
    logic [5:0]  read_slot;
    logic [3:0]  read_pos;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [6:0]  stored_count;
    logic        taken;
    logic        error_flag;
  } out_item_t;

  // Work for the back end: at most one store access plus the result flags.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       taken;
    logic       err;
    logic [6:0] stored_count;
  } back_op_t;

endpackage
`default_nettype wire

// File: hw/rtl/rsmp_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: hw/rtl/rsmp_front.sv
// Front end: config registers, record tracking and keep/replace decision.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_front #(
  parameter int MAX_RECORDS = 64,
  parameter int MAX_WIDTH   = 16,
  parameter int ELEM_BITS   = 16,
  parameter int ADDR_W      = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [rsmp_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [rsmp_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire rsmp_pkg::in_item_t             in_data,
  input  wire logic                           q_full,
  output      logic                           q_push,
  output      rsmp_pkg::back_op_t             q_op,
  output      logic [ADDR_W-1:0]              q_addr,
  output      logic [ELEM_BITS-1:0]           q_wdata
);
  import rsmp_pkg::*;

  localparam int FILL_W = $clog2(MAX_RECORDS + 1);
  localparam int SLOT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic [6:0]        res_size_r;
  logic [4:0]        asg_width_r;
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic [31:0]       seen_r, seen_nxt;
  logic [3:0]        pos_r, pos_nxt;
  logic              take_r, take_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [6:0]  k;
  logic [4:0]  w;
  logic [3:0]  pos0;
  logic [4:0]  pos_inc;
  logic        first;
  logic [31:0] seen_inc;
  logic [47:0] prod;
  logic [47:0] lim;
  logic        below_k;
  logic        rd_ok;
  logic        err;
  logic        accept;
  logic [31:0] elem32;

  always_comb begin
    if (res_size_r == 7'd0) begin
      k = 7'd1;
    end else if (32'(res_size_r) > MAX_RECORDS) begin
      k = 7'(MAX_RECORDS);
    end else begin
      k = res_size_r;
    end
    if (asg_width_r == 5'd0) begin
      w = 5'd1;
    end else if (32'(asg_width_r) > MAX_WIDTH) begin
      w = 5'(MAX_WIDTH);
    end else begin
      w = asg_width_r;
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign pos0     = ({1'b0, pos_r} >= w) ? 4'd0 : pos_r;
  assign first    = (pos0 == 4'd0);
  assign seen_inc = (seen_r == 32'hFFFF_FFFF) ? seen_r : seen_r + 32'd1;
  assign prod     = 48'(in_data.accept_draw) * 48'(seen_inc);
  assign lim      = {25'd0, k, 16'd0};
  assign below_k  = 32'(filled_r) < 32'(k);
  assign pos_inc  = {1'b0, pos0} + 5'd1;
  assign elem32   = {16'd0, in_data.elem_value};

  always_comb begin
    filled_nxt = filled_r;
    seen_nxt   = seen_r;
    pos_nxt    = pos_r;
    take_nxt   = take_r;
    slot_nxt   = slot_r;
    err        = 1'b0;
    rd_ok      = 1'b0;
    q_addr     = '0;
    if (in_data.cmd == CMD_READ) begin
      rd_ok  = (32'(in_data.read_slot) < 32'(filled_r)) && ({1'b0, in_data.read_pos} < w);
      err    = !rd_ok;
      q_addr = ADDR_W'(32'(in_data.read_slot) * MAX_WIDTH + 32'(in_data.read_pos));
    end else begin
      if (first) begin
        seen_nxt = seen_inc;
        take_nxt = 1'b0;
        if (below_k) begin
          slot_nxt   = SLOT_W'(filled_r);
          take_nxt   = 1'b1;
          filled_nxt = filled_r + FILL_W'(1);
        end else if (prod < lim) begin
          if ({1'b0, in_data.slot_draw} < k) begin
            slot_nxt = SLOT_W'(in_data.slot_draw);
            take_nxt = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      q_addr  = ADDR_W'(32'(slot_nxt) * MAX_WIDTH + 32'(pos0));
      pos_nxt = (pos_inc >= w) ? 4'd0 : pos_inc[3:0];
    end
  end

  always_comb begin
    q_push          = accept;
    q_op.wr         = (in_data.cmd == CMD_OFFER) && take_nxt;
    q_op.rd         = rd_ok;
    q_op.taken      = (in_data.cmd == CMD_OFFER) && take_nxt;
    q_op.err        = err;
    q_op.stored_count = 7'(filled_nxt);
    q_wdata         = elem32[ELEM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_size_r  <= RES_SIZE_RST;
      asg_width_r <= ASG_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RES_SIZE:  res_size_r  <= cfg_data[6:0];
        REG_ASG_WIDTH: asg_width_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      seen_r   <= '0;
      pos_r    <= '0;
      take_r   <= 1'b0;
      slot_r   <= '0;
    end else if (accept) begin
      filled_r <= filled_nxt;
      seen_r   <= seen_nxt;
      pos_r    <= pos_nxt;
      take_r   <= take_nxt;
      slot_r   <= slot_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rsmp_queue.sv
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_queue #(
  parameter int WIDTH = 37
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic             not_empty,
  output      logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rsmp_back.sv
// Back end: sample store access and result register.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_back #(
  parameter int ELEM_BITS = 16,
  parameter int DEPTH     = 1024,
  parameter int ADDR_W    = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_not_empty,
  output      logic                  q_pop,
  input  wire rsmp_pkg::back_op_t    q_op,
  input  wire logic [ADDR_W-1:0]     q_addr,
  input  wire logic [ELEM_BITS-1:0]  q_wdata,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      rsmp_pkg::out_item_t   out_data
);
  import rsmp_pkg::*;

  logic                 s1_valid_r;
  back_op_t             s1_op_r;
  logic                 s1_move;
  logic [ELEM_BITS-1:0] rdata;
  logic [31:0]          rdata32;
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;

  assign s1_move = s1_valid_r && (!out_valid_r || out_ready);
  assign q_pop   = q_not_empty && (!s1_valid_r || s1_move);
  assign rdata32 = 32'(rdata);

  rsmp_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (q_pop && (q_op.wr || q_op.rd)),
    .we    (q_op.wr),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (rdata)
  );

  always_comb begin
    out_nxt.read_value   = s1_op_r.rd ? rdata32[15:0] : 16'd0;
    out_nxt.stored_count = s1_op_r.stored_count;
    out_nxt.taken        = s1_op_r.taken;
    out_nxt.error_flag   = s1_op_r.err;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r <= q_op;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/reservoir_sampler.sv
// Top level: reservoir sampler, front end, queue and back end.
// An accepted item goes through the queue, the back-end stage and the result register.
// One item per cycle unless the queue is full; one store port, at most one access each.
// The front end decides each item combinationally (one 16x32 multiply and compare).
// Reset (synchronous, rst_n low) empties the sample and queue and loads register defaults;
// the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module reservoir_sampler #(
  parameter int MAX_RECORDS = 64,
  parameter int MAX_WIDTH   = 16,
  parameter int ELEM_BITS   = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [rsmp_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [rsmp_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire rsmp_pkg::in_item_t             in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      rsmp_pkg::out_item_t            out_data
);
  import rsmp_pkg::*;

  localparam int DEPTH  = MAX_RECORDS * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_W   = $bits(back_op_t);
  localparam int Q_W    = OP_W + ADDR_W + ELEM_BITS;

  logic                 q_full, q_push, q_pop, q_not_empty;
  back_op_t             f_op, b_op;
  logic [ADDR_W-1:0]    f_addr, b_addr;
  logic [ELEM_BITS-1:0] f_wdata, b_wdata;
  logic [Q_W-1:0]       q_out;

  assign cfg_ready = 1'b1;

  rsmp_front #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_WIDTH   (MAX_WIDTH),
    .ELEM_BITS   (ELEM_BITS),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (f_op),
    .q_addr    (f_addr),
    .q_wdata   (f_wdata)
  );

  rsmp_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_op, f_addr, f_wdata}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  assign b_op    = back_op_t'(q_out[Q_W-1 -: OP_W]);
  assign b_addr  = q_out[ELEM_BITS +: ADDR_W];
  assign b_wdata = q_out[ELEM_BITS-1:0];

  rsmp_back #(
    .ELEM_BITS (ELEM_BITS),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_op        (b_op),
    .q_addr      (b_addr),
    .q_wdata     (b_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for reservoir_sampler: shadow predictor, random offers and reads, backpressure.
`timescale 1ns / 1ps
module tb;
  import rsmp_pkg::*;

  localparam int STORE_ROWS  = 64;
  localparam int ROW_ELEMS   = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 200;
  localparam logic [CfgIndexW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  reservoir_sampler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int unsigned fail_cnt = 0;

  // shadow state of the sampler
  logic [15:0] shadow_store [STORE_ROWS*ROW_ELEMS];
  int unsigned shadow_filled = 0;
  bit   [31:0] shadow_seen = '0;
  int unsigned shadow_pos = 0;
  int unsigned shadow_slot = 0;
  bit          shadow_take = 1'b0;
  logic [6:0]  size_reg = RES_SIZE_RST;
  logic [4:0]  width_reg = ASG_WIDTH_RST;

  // stimulus planning: which stored elements are surely written
  int unsigned plan_filled = 0;
  int unsigned plan_pos = 0;
  int unsigned plan_slot = 0;
  bit          plan_append = 1'b0;
  bit          plan_written [STORE_ROWS*ROW_ELEMS];

  int unsigned hold_asks = 0;

  logic [7:0] size_set  [8] = '{8'h80, 8'd5, 8'hFF, 8'd17, 8'd64, 8'd40, 8'd1, 8'd127};
  logic [7:0] width_set [8] = '{8'd0, 8'd4, 8'd2, 8'hFF, 8'd16, 8'd7, 8'd1, 8'd31};

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > STORE_ROWS) return STORE_ROWS;
    return size_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_ELEMS) return ROW_ELEMS;
    return width_reg;
  endfunction

  function automatic out_item_t next_sample_result(in_item_t it);
    out_item_t        res;
    int unsigned      k;
    int unsigned      w;
    longint unsigned  lhs;
    longint unsigned  rhs;
    k = eff_size();
    w = eff_width();
    res = '0;
    if (it.cmd == CMD_READ) begin
      if (it.read_slot < shadow_filled && it.read_pos < w)
        res.read_value = shadow_store[it.read_slot * ROW_ELEMS + it.read_pos];
      else
        res.error_flag = 1'b1;
    end else begin
      if (shadow_pos >= w) shadow_pos = 0;
      if (shadow_pos == 0) begin
        if (shadow_seen != 32'hFFFF_FFFF) shadow_seen++;
        shadow_take = 1'b0;
        lhs = 64'(it.accept_draw) * 64'(shadow_seen);
        rhs = 64'(k) << 16;
        if (shadow_filled < k) begin
          shadow_slot = shadow_filled;
          shadow_take = 1'b1;
          shadow_filled++;
        end else if (lhs < rhs) begin
          if (it.slot_draw < k) begin
            shadow_slot = it.slot_draw;
            shadow_take = 1'b1;
          end else begin
            res.error_flag = 1'b1;
          end
        end
      end
      if (shadow_take) begin
        shadow_store[shadow_slot * ROW_ELEMS + shadow_pos] = it.elem_value;
        res.taken = 1'b1;
      end
      shadow_pos = (shadow_pos + 1 >= w) ? 0 : shadow_pos + 1;
    end
    res.stored_count = 7'(shadow_filled);
    return res;
  endfunction

  function automatic void queue_offer(logic [15:0] value, logic [15:0] accept,
                                      logic [5:0] sdraw);
    in_item_t    it;
    int unsigned w;
    it.cmd         = CMD_OFFER;
    it.elem_value  = value;
    it.accept_draw = accept;
    it.slot_draw   = sdraw;
    it.read_slot   = 6'($urandom);
    it.read_pos    = 4'($urandom);
    w = eff_width();
    if (plan_pos >= w) plan_pos = 0;
    if (plan_pos == 0) begin
      plan_append = plan_filled < eff_size();
      if (plan_append) begin
        plan_slot = plan_filled;
        plan_filled++;
      end
    end
    if (plan_append) plan_written[plan_slot * ROW_ELEMS + plan_pos] = 1'b1;
    plan_pos = (plan_pos + 1 >= w) ? 0 : plan_pos + 1;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_read(logic [5:0] slot, logic [3:0] pos);
    in_item_t it;
    it.cmd         = CMD_READ;
    it.elem_value  = 16'($urandom);
    it.accept_draw = 16'($urandom);
    it.slot_draw   = 6'($urandom);
    it.read_slot   = slot;
    it.read_pos    = pos;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void queue_rand_offer();
    logic [15:0] value;
    logic [15:0] accept;
    logic [5:0]  sdraw;
    case ($urandom_range(9))
      0:       value = 16'h0000;
      1:       value = 16'hFFFF;
      default: value = 16'($urandom);
    endcase
    case ($urandom_range(9))
      6, 7:    accept = 16'($urandom_range(255));
      8:       accept = 16'h0000;
      9:       accept = 16'hFFFF;
      default: accept = 16'($urandom);
    endcase
    if ($urandom_range(9) == 0) sdraw = 6'($urandom_range(STORE_ROWS - 1));
    else                        sdraw = 6'($urandom_range(eff_size() - 1));
    queue_offer(value, accept, sdraw);
  endfunction

  // reads only surely written elements, or deliberately out-of-range ones
  function automatic void queue_rand_read();
    int unsigned s;
    int unsigned p;
    int unsigned w;
    bit          found;
    w = eff_width();
    found = 1'b0;
    if ($urandom_range(4) != 0 && plan_filled > 0)
      for (int t = 0; t < 8 && !found; t++) begin
        s = $urandom_range(plan_filled - 1);
        p = $urandom_range(w - 1);
        found = plan_written[s * ROW_ELEMS + p];
      end
    if (!found) begin
      if (plan_filled < STORE_ROWS && (w == ROW_ELEMS || $urandom_range(1) == 1)) begin
        s = $urandom_range(STORE_ROWS - 1, plan_filled);
        p = $urandom_range(ROW_ELEMS - 1);
      end else if (w < ROW_ELEMS) begin
        s = $urandom_range(STORE_ROWS - 1);
        p = $urandom_range(ROW_ELEMS - 1, w);
      end else begin
        s = $urandom_range(plan_filled - 1);
        p = 0;
      end
    end
    queue_read(6'(s), 4'(p));
  endfunction

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RES_SIZE:  size_reg = val[6:0];
      REG_ASG_WIDTH: width_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire)
        expected_results.insert(expected_results.size(), next_sample_result(in_data));
      if (!in_valid || fire) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus long hold-offs on request
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned recv_cyc = 0;
  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      recv_cyc++;
      if (hold_asks != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((recv_cyc >> 8) % 4)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(1) == 1);
          2:       rdy = ($urandom_range(3) == 0);
          default: rdy = (recv_cyc % 5) < 3;
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        cmp_field("read_value", want.read_value, out_data.read_value);
        cmp_field("stored_count", 16'(want.stored_count), 16'(out_data.stored_count));
        cmp_field("taken", 16'(want.taken), 16'(out_data.taken));
        cmp_field("error_flag", 16'(want.error_flag), 16'(out_data.error_flag));
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_SPARE_2, 8'($urandom));
    write_reg(REG_SPARE_3, 8'hFF);
    write_reg(REG_RES_SIZE, 8'd2);
    write_reg(REG_ASG_WIDTH, 8'd3);

    queue_read(6'd0, 4'd0);                         // nothing stored yet
    queue_offer(16'h0000, 16'hFFFF, 6'd63);         // appended to slot 0
    queue_read(6'd0, 4'd0);                         // read mid-record
    queue_offer(16'hFFFF, 16'($urandom), 6'($urandom));
    queue_offer(16'($urandom), 16'($urandom), 6'($urandom));
    repeat (3) queue_offer(16'($urandom), 16'($urandom), 6'($urandom));
    queue_offer(16'h1234, 16'hFFFF, 6'd0);          // sample full: rejected
    repeat (2) queue_offer(16'($urandom), 16'($urandom), 6'($urandom));
    queue_offer(16'h5678, 16'h0000, 6'd63);         // draw passes, slot draw out of range: error
    repeat (2) queue_offer(16'($urandom), 16'($urandom), 6'($urandom));
    queue_offer(16'hA5A5, 16'h0000, 6'd1);          // replaces slot 1
    repeat (2) queue_offer(16'($urandom), 16'($urandom), 6'($urandom));
    queue_read(6'd1, 4'd2);
    queue_read(6'd1, 4'd0);
    queue_read(6'd2, 4'd0);                         // slot not filled
    queue_read(6'd0, 4'd3);                         // position beyond width
    queue_read(6'd63, 4'd15);
    drain();

    foreach (size_set[p]) begin
      write_reg(REG_RES_SIZE, size_set[p]);
      write_reg(REG_ASG_WIDTH, width_set[p]);
      n = PHASE_ITEMS + $urandom_range(7);
      for (int i = 0; i < n; i++)
        if ($urandom_range(9) < 7) queue_rand_offer();
        else                       queue_rand_read();
      if (p % 3 == 1) hold_asks++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && expected_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
